[rtl/key_debounce_repeat_longpress_top_defines.svh]
// Assertion macros for the key debounce block.
`ifndef KEY_DEBOUNCE_REPEAT_LONGPRESS_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_REPEAT_LONGPRESS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define KDRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define KDRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KDRL_ASSERT(lbl, prop, msg)
`define KDRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/kdrl_pkg.sv]
// Shared types and constants for the key debounce block.
package kdrl_pkg;

    localparam int HOLD_W  = 16;
    localparam int DEB_W   = 8;
    localparam int TICK_W  = 16;
    localparam int NRA_W   = (HOLD_W > TICK_W) ? HOLD_W : TICK_W;
    localparam int SUM_W   = NRA_W + 1;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST     = DEB_W'(3);
    localparam logic [TICK_W-1:0] REPEAT_START_RST = TICK_W'(50);
    localparam logic [TICK_W-1:0] REPEAT_PERIOD_RST = TICK_W'(10);
    localparam logic [TICK_W-1:0] LONG_PRESS_RST   = TICK_W'(50);

    localparam logic [1:0] REG_DEBOUNCE      = 2'd0;
    localparam logic [1:0] REG_REPEAT_START  = 2'd1;
    localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;
    localparam logic [1:0] REG_LONG_PRESS    = 2'd3;

    typedef logic [HOLD_W-1:0] t_hold;
    typedef logic [NRA_W-1:0]  t_nra;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [TICK_W-1:0] repeat_start_ticks;
        logic [TICK_W-1:0] repeat_period_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic pin_level;
        logic take_pressed;
        logic take_repeat;
        logic take_long;
    } t_item;

    typedef struct packed {
        logic stable_key;
        logic pressed_taken;
        logic repeat_taken;
        logic long_taken;
    } t_res;

    typedef struct packed {
        logic level;
        logic pressed_flag;
        logic long_flag;
        logic long_latched;
    } t_status;

endpackage

[rtl/kdrl_cfg.sv]
// Configuration register file with its bus port.
module kdrl_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kdrl_pkg::ADDR_W-1:0] paddr,
    input  logic [kdrl_pkg::DATA_W-1:0] pwdata,
    output logic [kdrl_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output kdrl_pkg::t_cfg             o_cfg
);
    import kdrl_pkg::*;

    t_cfg       r_cfg;
    logic       s_wr;
    logic [1:0] s_idx;

    assign s_wr   = psel && penable && pwrite;
    assign s_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEBOUNCE_RST;
            r_cfg.repeat_start_ticks  <= REPEAT_START_RST;
            r_cfg.repeat_period_ticks <= REPEAT_PERIOD_RST;
            r_cfg.long_press_ticks    <= LONG_PRESS_RST;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_DEBOUNCE:      r_cfg.debounce_ticks      <= pwdata[DEB_W-1:0];
                REG_REPEAT_START:  r_cfg.repeat_start_ticks  <= pwdata[TICK_W-1:0];
                REG_REPEAT_PERIOD: r_cfg.repeat_period_ticks <= pwdata[TICK_W-1:0];
                REG_LONG_PRESS:    r_cfg.long_press_ticks    <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (s_idx)
            REG_DEBOUNCE:      prdata = DATA_W'(r_cfg.debounce_ticks);
            REG_REPEAT_START:  prdata = DATA_W'(r_cfg.repeat_start_ticks);
            REG_REPEAT_PERIOD: prdata = DATA_W'(r_cfg.repeat_period_ticks);
            REG_LONG_PRESS:    prdata = DATA_W'(r_cfg.long_press_ticks);
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/kdrl_core.sv]
// Key state registers and the per-tick debounce, repeat and long-press update.
module kdrl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  kdrl_pkg::t_cfg    i_cfg,
    input  kdrl_pkg::t_item   i_item,
    output kdrl_pkg::t_res    o_res,
    output kdrl_pkg::t_status o_status
);
    import kdrl_pkg::*;

    localparam t_hold HOLD_MAX = '1;

    logic             r_level, n_level;
    logic [DEB_W-1:0] r_mc, n_mc;
    t_hold            r_held, n_held;
    t_nra             r_nra, n_nra;
    logic             r_pflag, n_pflag;
    logic             r_rflag, n_rflag;
    logic             r_lflag, n_lflag;
    logic             r_latch, n_latch;

    logic             s_mc_inc_ok;
    logic [DEB_W-1:0] s_mc_inc;
    logic             s_accept;
    t_hold            s_held2, s_held3;
    t_nra             s_nra2;
    logic [SUM_W-1:0] s_sum;
    logic             s_latch2;

    always_comb begin
        s_mc_inc_ok = (r_mc != '1);
        s_mc_inc    = s_mc_inc_ok ? r_mc + DEB_W'(1) : r_mc;
        // A zero debounce setting behaves as one since the count is at least one here.
        s_accept    = (i_item.pin_level != r_level) && (s_mc_inc >= i_cfg.debounce_ticks);

        n_mc    = ((i_item.pin_level == r_level) || s_accept) ? '0 : s_mc_inc;
        n_level = s_accept ? i_item.pin_level : r_level;
        s_held2 = s_accept ? '0 : r_held;
        s_nra2  = s_accept ? NRA_W'(i_cfg.repeat_start_ticks) : r_nra;
        s_latch2 = s_accept ? 1'b0 : r_latch;

        n_pflag = (r_pflag && !i_item.take_pressed) || (s_accept && i_item.pin_level);
        n_rflag = r_rflag && !i_item.take_repeat;
        n_lflag = r_lflag && !i_item.take_long;

        s_held3 = (s_held2 == HOLD_MAX) ? s_held2 : s_held2 + HOLD_W'(1);
        s_sum   = SUM_W'(s_nra2) + SUM_W'(i_cfg.repeat_period_ticks);

        n_held  = s_held2;
        n_nra   = s_nra2;
        n_latch = s_latch2;
        if (n_level) begin
            n_held = s_held3;
            if (NRA_W'(s_held3) >= s_nra2) begin
                n_rflag = 1'b1;
                // The repeat point advances only while it stays at or below the hold count ceiling.
                if (s_sum <= SUM_W'(HOLD_MAX)) begin
                    n_nra = s_sum[NRA_W-1:0];
                end
            end
            if (!s_latch2 && (NRA_W'(s_held3) >= NRA_W'(i_cfg.long_press_ticks))) begin
                n_lflag = 1'b1;
                n_latch = 1'b1;
            end
        end

        o_res.stable_key    = n_level;
        o_res.pressed_taken = i_item.take_pressed && r_pflag;
        o_res.repeat_taken  = i_item.take_repeat && r_rflag;
        o_res.long_taken    = i_item.take_long && r_lflag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_mc    <= '0;
            r_held  <= '0;
            r_nra   <= NRA_W'(REPEAT_START_RST);
            r_pflag <= 1'b0;
            r_rflag <= 1'b0;
            r_lflag <= 1'b0;
            r_latch <= 1'b0;
        end else if (i_en) begin
            r_level <= n_level;
            r_mc    <= n_mc;
            r_held  <= n_held;
            r_nra   <= n_nra;
            r_pflag <= n_pflag;
            r_rflag <= n_rflag;
            r_lflag <= n_lflag;
            r_latch <= n_latch;
        end
    end

    assign o_status.level        = r_level;
    assign o_status.pressed_flag = r_pflag;
    assign o_status.long_flag    = r_lflag;
    assign o_status.long_latched = r_latch;

endmodule

[rtl/key_debounce_repeat_longpress_top.sv]
// Top level of the debounced key with auto-repeat and long-press events.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready      | i_pin_level i_take_pressed i_take_repeat
//           |                              | i_take_long
//  output   | o_out_valid / i_out_ready    | o_stable_key o_pressed_taken o_repeat_taken
//           |                              | o_long_taken
//  config   | psel penable pwrite / pready | paddr pwdata prdata
//
// A tick is registered on entry in the input register, updates the key state and lands in the
// result register, which raises output valid; a stalled result holds the tick at the input.
// One tick is taken per cycle while the result is not stalled.
// The key state moves only when a tick leaves the input register for the result register.
// While the result waits for its transfer, one more tick can be held at the input.
// Synchronous reset clears the key state and handshake and loads the config defaults.
`include "key_debounce_repeat_longpress_top_defines.svh"

module key_debounce_repeat_longpress_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_pin_level,
    input  logic                        i_take_pressed,
    input  logic                        i_take_repeat,
    input  logic                        i_take_long,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_stable_key,
    output logic                        o_pressed_taken,
    output logic                        o_repeat_taken,
    output logic                        o_long_taken,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kdrl_pkg::ADDR_W-1:0] paddr,
    input  logic [kdrl_pkg::DATA_W-1:0] pwdata,
    output logic [kdrl_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import kdrl_pkg::*;

    t_cfg    s_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_res    r_res, s_res;
    logic    r_out_valid;
    logic    s_adv;
    t_status s_stat;

    kdrl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    kdrl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s_adv),
        .i_cfg    (s_cfg),
        .i_item   (r_item),
        .o_res    (s_res),
        .o_status (s_stat)
    );

    // A held tick moves on whenever the result register is empty or being emptied.
    assign s_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.pin_level    <= i_pin_level;
            r_item.take_pressed <= i_take_pressed;
            r_item.take_repeat  <= i_take_repeat;
            r_item.take_long    <= i_take_long;
        end
        if (s_adv) begin
            r_res <= s_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stable_key    = r_res.stable_key;
    assign o_pressed_taken = r_res.pressed_taken;
    assign o_repeat_taken  = r_res.repeat_taken;
    assign o_long_taken    = r_res.long_taken;

    `KDRL_ASSERT(a_stall_only_on_full_out, !o_in_ready |-> (o_out_valid && !i_out_ready), "input stalled without a stalled result")
    `KDRL_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !o_out_valid, "result valid right after reset")
    `KDRL_ASSERT(a_press_event_level, $rose(s_stat.pressed_flag) |-> s_stat.level, "press event without a pressed level")
    `KDRL_ASSERT(a_long_event_latched, $rose(s_stat.long_flag) |-> (s_stat.long_latched && s_stat.level), "long-press event without latch")

endmodule
